// File: design/mcu_pkg.sv
// mcu_pkg: shared widths, register indexes and control/status structs
// for the multiset combination unranker; no dependencies
package mcu_pkg;

    // request and result field widths
    localparam int RANK_W    = 42;
    localparam int ELEM_W    = 8;
    localparam int POS_W     = 3;

    // binomial entries saturate at 2^42, just above any remainder
    localparam int BINOM_W   = RANK_W + 1;
    localparam logic [BINOM_W-1:0] BINOM_CAP = BINOM_W'(1) << RANK_W;

    // configuration port
    localparam int TOP_W      = 7;
    localparam int SIZE_W     = 4;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_ADDR_W-1:0] CFG_TOP_VALUE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COMBO_SIZE = 1'b1;

    localparam logic [TOP_W-1:0]  TOP_RESET  = 7'd3;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd5;

    // commands from the controller to the datapath
    typedef struct packed {
        logic fill;     // write one table row, advance pascal row
        logic load;     // take a new request
        logic read;     // fetch binomial for the current midpoint
        logic compare;  // narrow the search interval
        logic emit;     // output one element, move to the next slot
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic fill_last;    // last table row being written
        logic j_zero;       // no open slots left
        logic search_done;  // interval collapsed to one value
    } t_status;

endpackage

// File: design/mcu_ram.sv
// mcu_ram: generic single write port, single read port ram with registered read
// no dependencies
module mcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/mcu_datapath.sv
// mcu_datapath: binomial table fill, binary search and remainder update
// depends on mcu_pkg and mcu_ram
module mcu_datapath #(
    parameter int MAX_VALUE = 127,
    parameter int MAX_SIZE  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mcu_pkg::t_cmd                    i_cmd,
    output mcu_pkg::t_status                 o_status,
    input  logic [mcu_pkg::RANK_W-1:0]       i_rank,
    input  logic [$clog2(MAX_VALUE+1)-1:0]   i_top,
    input  logic [$clog2(MAX_SIZE+1)-1:0]    i_size,
    output logic                             o_valid,
    output logic [mcu_pkg::ELEM_W-1:0]       o_element,
    output logic [mcu_pkg::POS_W-1:0]        o_position,
    output logic                             o_last
);

    localparam int VW   = $clog2(MAX_VALUE + 1);
    localparam int JW   = $clog2(MAX_SIZE + 1);
    localparam int ROWS = MAX_VALUE + MAX_SIZE;
    localparam int AW   = $clog2(ROWS);
    localparam int BW   = mcu_pkg::BINOM_W;
    localparam int RW   = MAX_SIZE * BW;

    // table fill state
    logic [AW-1:0] r_fill;
    logic [BW-1:0] r_prev [MAX_SIZE];
    logic [BW-1:0] n_prev [MAX_SIZE];
    logic [RW-1:0] w_row;

    // search state
    logic [mcu_pkg::RANK_W-1:0] r_rem;
    logic [JW-1:0]              r_j;
    logic [VW-1:0]              r_lo;
    logic [VW-1:0]              r_hi;
    logic [BW-1:0]              r_best;

    // result registers
    logic                       r_valid;
    logic [mcu_pkg::ELEM_W-1:0] r_element;
    logic [mcu_pkg::POS_W-1:0]  r_position;
    logic                       r_last;

    logic [VW:0]   w_mid_sum;
    logic [VW-1:0] w_mid;
    logic [AW-1:0] w_raddr;
    logic [RW-1:0] w_rdata;
    logic [JW-1:0] w_col;
    logic [BW-1:0] w_binom;
    logic          w_fit;

    // next pascal row: column c holds binomial(n, c+1), binomial(n, 0) left of column zero is one
    always_comb begin
        logic [BW-1:0] left;
        logic [BW:0]   sum;
        for (int c = 0; c < MAX_SIZE; c++) begin
            left = (c == 0) ? BW'(1) : r_prev[(c == 0) ? 0 : c - 1];
            sum  = {1'b0, left} + {1'b0, r_prev[c]};
            n_prev[c] = (sum > {1'b0, mcu_pkg::BINOM_CAP}) ? mcu_pkg::BINOM_CAP
                                                           : sum[BW-1:0];
            w_row[c*BW +: BW] = r_prev[c];
        end
    end

    // midpoint rounded up, table row v+j-1 and column j-1
    assign w_mid_sum = (VW+1)'(r_lo) + (VW+1)'(r_hi) + (VW+1)'(1);
    assign w_mid     = w_mid_sum[VW:1];
    assign w_raddr   = AW'(w_mid) + AW'(r_j) - AW'(1);
    assign w_col     = r_j - JW'(1);
    assign w_binom   = w_rdata[w_col*BW +: BW];
    assign w_fit     = (w_binom <= {1'b0, r_rem});

    mcu_ram #(
        .WIDTH (RW),
        .DEPTH (ROWS)
    ) u_binom_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fill),
        .i_waddr (r_fill),
        .i_wdata (w_row),
        .i_re    (i_cmd.read),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // fill counter, pascal row and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_valid <= 1'b0;
            for (int c = 0; c < MAX_SIZE; c++) begin
                r_prev[c] <= '0;
            end
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.fill) begin
                r_fill <= r_fill + AW'(1);
                for (int c = 0; c < MAX_SIZE; c++) begin
                    r_prev[c] <= n_prev[c];
                end
            end
        end
    end

    // search registers and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem  <= i_rank - mcu_pkg::RANK_W'(1);
            r_j    <= i_size;
            r_lo   <= '0;
            r_hi   <= i_top;
            r_best <= '0;
        end else if (i_cmd.compare) begin
            if (w_fit) begin
                r_lo   <= w_mid;
                r_best <= w_binom;
            end else begin
                r_hi <= w_mid - VW'(1);
            end
        end else if (i_cmd.emit) begin
            r_element  <= mcu_pkg::ELEM_W'(r_lo) + mcu_pkg::ELEM_W'(1);
            r_position <= mcu_pkg::POS_W'(w_col);
            r_last     <= (r_j == JW'(1));
            r_rem      <= r_rem - r_best[mcu_pkg::RANK_W-1:0];
            r_j        <= r_j - JW'(1);
            r_lo       <= '0;
            r_hi       <= i_top;
            r_best     <= '0;
        end
    end

    assign o_status.fill_last   = (r_fill == AW'(ROWS - 1));
    assign o_status.j_zero      = (r_j == '0);
    assign o_status.search_done = (r_lo == r_hi);

    assign o_valid    = r_valid;
    assign o_element  = r_element;
    assign o_position = r_position;
    assign o_last     = r_last;

    // the chosen binomial never exceeds the remainder it is taken from
    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_best <= {1'b0, r_rem})
        else $error("selected binomial exceeds remainder");

    // every emit shows up as exactly one strobe in the next cycle
    a_emit_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_valid)
        else $error("emit without result strobe");

endmodule

// File: design/mcu_ctrl.sv
// mcu_ctrl: controller state machine for table fill and per-slot search
// depends on mcu_pkg
module mcu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  mcu_pkg::t_status i_status,
    output mcu_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    typedef enum logic [4:0] {
        S_FILL   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_CMP    = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_status.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_status.j_zero) begin
                    n_state = S_IDLE;
                end else if (i_status.search_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.read = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_SEARCH;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_SEARCH;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register, table fill runs first after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // an accepted request always enters the search
    a_load_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> r_state == S_SEARCH)
        else $error("accepted request did not start search");

    // every table read is followed by its compare
    a_read_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.read |=> o_cmd.compare)
        else $error("table read without compare");

endmodule

// File: design/multiset_combination_unrank.sv
// multiset_combination_unrank: top level, configuration registers and wiring
// depends on mcu_pkg, mcu_ctrl, mcu_datapath (and mcu_ram through it)
//
// usage
//   request: drive i_rank and raise start; it is taken at a clock edge where
//   start is high and busy is low. busy stays high until all results are out.
//   results: one per slot, slot combo_size-1 first, each shown for a single
//   cycle with o_valid high; o_last marks slot 0. the receiver cannot stall,
//   so results must be taken when o_valid is high. combo_size 0 gives none.
//   configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_addr
//   (0 top_value, 1 combo_size) at once; write only while busy is low.
//   reset: registers return to top_value 3, combo_size 5, then the binomial
//   table is built one row a cycle, MAX_VALUE+MAX_SIZE rows (135 by
//   default), with busy high; requests are taken after that.
//   search: each slot runs a binary search over the table ram, each step a
//   read from the search state then a compare state, at most ceil(log2(top+1))
//   steps, then an emit state; the table ram read is registered, so a step
//   has a separate read and compare.
module multiset_combination_unrank #(
    parameter int MAX_VALUE = 127,
    parameter int MAX_SIZE  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [mcu_pkg::RANK_W-1:0]       i_rank,
    output logic                             o_valid,
    output logic [mcu_pkg::ELEM_W-1:0]       o_element,
    output logic [mcu_pkg::POS_W-1:0]        o_position,
    output logic                             o_last,
    input  logic                             i_cfg_we,
    input  logic [mcu_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [mcu_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int VW = $clog2(MAX_VALUE + 1);
    localparam int JW = $clog2(MAX_SIZE + 1);

    logic [mcu_pkg::TOP_W-1:0]  r_top_value;
    logic [mcu_pkg::SIZE_W-1:0] r_combo_size;
    logic [VW-1:0]              w_top;
    logic [JW-1:0]              w_size;
    mcu_pkg::t_cmd              w_cmd;
    mcu_pkg::t_status           w_status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_value  <= mcu_pkg::TOP_RESET;
            r_combo_size <= mcu_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mcu_pkg::CFG_TOP_VALUE:  r_top_value  <= i_cfg_wdata;
                mcu_pkg::CFG_COMBO_SIZE: r_combo_size <= i_cfg_wdata[mcu_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp to the table bounds
    assign w_top  = (16'(r_top_value) > 16'(MAX_VALUE)) ? VW'(MAX_VALUE) : VW'(r_top_value);
    assign w_size = (16'(r_combo_size) > 16'(MAX_SIZE)) ? JW'(MAX_SIZE) : JW'(r_combo_size);

    mcu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    mcu_datapath #(
        .MAX_VALUE (MAX_VALUE),
        .MAX_SIZE  (MAX_SIZE)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_rank     (i_rank),
        .i_top      (w_top),
        .i_size     (w_size),
        .o_valid    (o_valid),
        .o_element  (o_element),
        .o_position (o_position),
        .o_last     (o_last)
    );

    // the last result of a request is never followed directly by another
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result strobe right after last result");

endmodule
